[hdl/dht_pkg.sv]
`default_nettype none

package dht_pkg;

  // Field widths of the stream items
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OUT_W = 10;
  localparam int unsigned CNT_W = 11;

  // Stream packing: key, value in; collisions, slot, occupancy out
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  // Remainder unit: key bits consumed per cycle and steps per key
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = KEY_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;    // clear one used bit, advance the clear address
    logic load;        // capture key and value, restart the remainder unit
    logic div_step;    // consume DIV_BITS key bits
    logic probe_init;  // first probe index and step from the remainders
    logic probe_adv;   // move to the next probe index
    logic store;       // write the entry, mark used, load the result
    logic full_out;    // load a table-full result
  } dht_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;    // clear address at the last slot
    logic div_last;    // final remainder step this cycle
    logic slot_free;   // slot at the probe index is free
    logic probe_last;  // this probe is the last one allowed
    logic out_free;    // result register can take a new item
  } dht_stat_t;

endpackage

`default_nettype wire

[hdl/dht_ctrl.sv]
`default_nettype none

module dht_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dht_pkg::dht_stat_t  stat_i,
  output dht_pkg::dht_cmd_t        cmd_o
);
  import dht_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_INIT  = 6'b001000,
    S_RD    = 6'b010000,
    S_CHK   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_RD;
      end
      S_RD: begin
        // memory read of the probe slot is in flight
        state_d = S_CHK;
      end
      S_CHK: begin
        priority if (stat_i.slot_free) begin
          if (stat_i.out_free) begin
            cmd_o.store = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (stat_i.probe_last) begin
          if (stat_i.out_free) begin
            cmd_o.full_out = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.probe_adv = 1'b1;
          state_d         = S_RD;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_load_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DIV)
    else $error("accepted item did not start the remainder unit");

endmodule

`default_nettype wire

[hdl/dht_datapath.sv]
`default_nettype none

module dht_datapath #(
  parameter int unsigned TABLE_SLOTS = 1021
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dht_pkg::dht_cmd_t             cmd_i,
  output dht_pkg::dht_stat_t                 stat_o,
  input  wire logic [dht_pkg::KEY_W-1:0]     key_i,
  input  wire logic [dht_pkg::VAL_W-1:0]     value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dht_pkg::OUT_W-1:0]          collisions_o,
  output logic [dht_pkg::OUT_W-1:0]          slot_o,
  output logic                               table_full_o,
  output logic [dht_pkg::OUT_W-1:0]          occupancy_o
);
  import dht_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned RW = IW + 1;
  localparam int unsigned PW = $clog2(TABLE_SLOTS + 1);
  localparam logic [RW-1:0] SLOTS_R    = RW'(TABLE_SLOTS);
  localparam logic [RW-1:0] SLOTS_M1_R = RW'(TABLE_SLOTS - 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_SLOTS - 1);
  localparam logic [PW-1:0] LAST_PROBE = PW'(TABLE_SLOTS - 1);
  localparam logic [OUT_W-1:0] FULL_COLL = OUT_W'(TABLE_SLOTS);

  // Table storage
  logic             used_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem  [TABLE_SLOTS];
  logic [VAL_W-1:0] val_mem  [TABLE_SLOTS];
  logic             rd_used_q;

  logic [IW-1:0]        clr_addr_q;
  logic [KEY_W-1:0]     key_q;
  logic [VAL_W-1:0]     val_q;
  logic [KEY_W-1:0]     sh_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [RW-1:0]        rem_slots_q, rem_slots_d;
  logic [RW-1:0]        rem_step_q, rem_step_d;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        step_q;
  logic [PW-1:0]        probes_q;
  logic [CNT_W-1:0]     used_cnt_q;
  logic [CNT_W-1:0]     used_cnt_inc;
  logic [RW-1:0]        idx_sum;
  logic [IW-1:0]        idx_next;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;

  // Remainder unit: DIV_BITS restoring steps per cycle for both moduli
  always_comb begin
    rem_slots_d = rem_slots_q;
    rem_step_d  = rem_step_q;
    for (int i = 0; i < int'(DIV_BITS); i++) begin
      rem_slots_d = {rem_slots_d[RW-2:0], sh_q[KEY_W-1-i]};
      if (rem_slots_d >= SLOTS_R) rem_slots_d = rem_slots_d - SLOTS_R;
      rem_step_d = {rem_step_d[RW-2:0], sh_q[KEY_W-1-i]};
      if (rem_step_d >= SLOTS_M1_R) rem_step_d = rem_step_d - SLOTS_M1_R;
    end
  end

  // Next probe index: sum stays below twice the slot count
  assign idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
  assign idx_next = (idx_sum >= SLOTS_R) ? IW'(idx_sum - SLOTS_R) : IW'(idx_sum);

  assign used_cnt_inc = used_cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      div_cnt_q  <= '0;
      used_cnt_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + IW'(1);
      if (cmd_i.load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.store) used_cnt_q <= used_cnt_inc;
      if (cmd_i.store || cmd_i.full_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q       <= key_i;
      val_q       <= value_i;
      sh_q        <= key_i;
      rem_slots_q <= '0;
      rem_step_q  <= '0;
    end else if (cmd_i.div_step) begin
      sh_q        <= sh_q << DIV_BITS;
      rem_slots_q <= rem_slots_d;
      rem_step_q  <= rem_step_d;
    end
    if (cmd_i.probe_init) begin
      idx_q    <= IW'(rem_slots_q);
      step_q   <= IW'(rem_step_q + RW'(1));
      probes_q <= '0;
    end else if (cmd_i.probe_adv) begin
      idx_q    <= idx_next;
      probes_q <= probes_q + PW'(1);
    end
    if (cmd_i.store) begin
      collisions_o <= OUT_W'(probes_q);
      slot_o       <= OUT_W'(idx_q);
      table_full_o <= 1'b0;
      occupancy_o  <= OUT_W'(used_cnt_inc);
    end else if (cmd_i.full_out) begin
      collisions_o <= FULL_COLL;
      slot_o       <= '0;
      table_full_o <= 1'b1;
      occupancy_o  <= OUT_W'(used_cnt_q);
    end
  end

  // Used-bit memory: one write port shared by the clear sweep and inserts
  assign wr_en   = cmd_i.clr_step | cmd_i.store;
  assign wr_addr = cmd_i.clr_step ? clr_addr_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) used_mem[wr_addr] <= cmd_i.store;
    rd_used_q <= used_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      key_mem[idx_q] <= key_q;
      val_mem[idx_q] <= val_q;
    end
  end

  assign stat_o.clr_last   = (clr_addr_q == LAST_IDX);
  assign stat_o.div_last   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat_o.slot_free  = ~rd_used_q;
  assign stat_o.probe_last = (probes_q == LAST_PROBE);
  assign stat_o.out_free   = ~out_valid_o | out_ready_i;

  a_store_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.store || cmd_i.full_out) |-> stat_o.out_free)
    else $error("result loaded over an untaken item");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=> used_cnt_q == $past(used_cnt_inc))
    else $error("occupancy count did not advance on insert");

endmodule

`default_nettype wire

[hdl/double_hash_table_insert.sv]
// Double-hashing insert into an open-addressed table of TABLE_SLOTS slots.
//
// Input channel (s_axis): one item is a key and a value. The first probe
// slot is key mod TABLE_SLOTS and the probe step is key mod (TABLE_SLOTS-1)
// plus one. The key and value are written to the first free slot found.
// Output channel (m_axis): one item per input, carrying the collision
// count, the chosen slot and the occupancy after the insert; tuser flags a
// full table (every allowed probe hit an occupied slot, nothing stored).
//
// Sequence: an accepted item passes through the remainder unit (4 key
// bits per cycle), then a step that sets up the first probe; each probe is
// then a registered read of the used-bit memory followed by the check.
// One item is in work at a time: the next item is taken the cycle after
// the result is loaded, so a new item is not accepted before the last
// one's result is loaded.
// Reset: the used-bit memory is swept clear after reset, one slot per
// cycle; s_axis_tready stays low meanwhile.
// Stall: a waiting result holds in the output register; the next item's
// result waits in the check step until that register is taken.
`default_nettype none

module double_hash_table_insert #(
  parameter int unsigned TABLE_SLOTS = 1021
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // s_axis_tdata: key [31:0], value [63:32]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // m_axis_tdata: collisions [9:0], slot [19:10], occupancy [29:20], zero pad
  // m_axis_tuser: table_full [0]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [dht_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tuser
);
  import dht_pkg::*;

  dht_cmd_t         cmd;
  dht_stat_t        stat;
  logic [OUT_W-1:0] collisions;
  logic [OUT_W-1:0] slot;
  logic [OUT_W-1:0] occupancy;

  // Sequencer: clear sweep, remainder steps, probe loop, result handoff
  dht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Remainder unit, probe index arithmetic, table memories, result register
  dht_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_i        (s_axis_tdata[KEY_W-1:0]),
    .value_i      (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .collisions_o (collisions),
    .slot_o       (slot),
    .table_full_o (m_axis_tuser),
    .occupancy_o  (occupancy)
  );

  // Pack the result fields, lowest field first, zero-filled to 32 bits
  assign m_axis_tdata = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}}, occupancy, slot, collisions};

endmodule

`default_nettype wire
